// ----- design/simplex_tableau_solver_macros.svh -----
// Assertion macros used by the simplex tableau solver top level.
`ifndef SIMPLEX_TABLEAU_SOLVER_MACROS_SVH
`define SIMPLEX_TABLEAU_SOLVER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define STS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define STS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sts_pkg.sv -----
// Types, codes and saturating Q16.16 helpers of the simplex tableau solver.
package sts_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD_COEF = 2'd0,
    REQ_LOAD_RHS  = 2'd1,
    REQ_LOAD_COST = 2'd2,
    REQ_SOLVE     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_ROWS  = 2'd0,
    CFG_COLS  = 2'd1,
    CFG_TOL   = 2'd2,
    CFG_LIMIT = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    ST_OPTIMAL   = 2'd0,
    ST_UNBOUNDED = 2'd1,
    ST_LIMIT     = 2'd2
  } status_e;

  typedef enum logic {
    KIND_OBJECTIVE = 1'b0,
    KIND_ROW       = 1'b1
  } kind_e;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + $signed({b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) - $signed({b[31], b});
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

  // Scales a full product back to Q16.16, truncating toward zero, and saturates.
  function automatic logic signed [31:0] q_mul_scale(input logic signed [63:0] p);
    logic signed [63:0] adj;
    logic signed [47:0] s;
    adj = p[63] ? (p + 64'sd65535) : p;
    s = adj[63:16];
    if (s > $signed(48'h0000_7FFF_FFFF)) begin
      return Q_MAX;
    end
    if (s < $signed(48'hFFFF_8000_0000)) begin
      return Q_MIN;
    end
    return s[31:0];
  endfunction

endpackage

// ----- design/simplex_tableau_solver.sv -----
// Simplex tableau solver top level: tableau memory, pivot sequencer and result register.
// Load items are accepted one per cycle and give no result; a solve item holds the input stalled.
// Each pivot uses a single divider, shared by the ratio test and the pivot-row normalisation.
// Reporting first sums the objective over the rows, then gives one result per cycle while the output is not stalled.
// Reset restores default registers and zeroes the tableau through per-entry valid bits.
`include "simplex_tableau_solver_macros.svh"

module simplex_tableau_solver #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [2:0]         row_index_i,
  input  logic [3:0]         col_index_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [2:0]         basis_row_o,
  output logic [3:0]         basic_column_o,
  output logic signed [31:0] amount_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int AW    = RIW + CIW;
  localparam int DEPTH = 1 << AW;
  localparam int BW    = $clog2(MAX_COLS + MAX_ROWS);

  typedef enum logic [30:0] {
    S_IDLE  = 31'h0000_0001,
    S_COL   = 31'h0000_0002,
    S_DEC   = 31'h0000_0004,
    S_RRD   = 31'h0000_0008,
    S_RWAIT = 31'h0000_0010,
    S_RDIV  = 31'h0000_0020,
    S_RNEXT = 31'h0000_0040,
    S_NRD   = 31'h0000_0080,
    S_NWAIT = 31'h0000_0100,
    S_NDIV  = 31'h0000_0200,
    S_NRS   = 31'h0000_0400,
    S_EBEG  = 31'h0000_0800,
    S_ETW   = 31'h0000_1000,
    S_ERD1  = 31'h0000_2000,
    S_ERD2  = 31'h0000_4000,
    S_EMUL  = 31'h0000_8000,
    S_EWR   = 31'h0001_0000,
    S_ERS   = 31'h0002_0000,
    S_ERS2  = 31'h0004_0000,
    S_ERS3  = 31'h0008_0000,
    S_ENEXT = 31'h0010_0000,
    S_CRD   = 31'h0020_0000,
    S_CMUL  = 31'h0040_0000,
    S_CSAT  = 31'h0080_0000,
    S_CWR   = 31'h0100_0000,
    S_PIV   = 31'h0200_0000,
    S_OMUL  = 31'h0400_0000,
    S_OSAT  = 31'h0800_0000,
    S_OADD  = 31'h1000_0000,
    S_OUT0  = 31'h2000_0000,
    S_OUTR  = 31'h4000_0000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]  rows_q, rows_d;
  logic [4:0]  cols_q, cols_d;
  logic [15:0] tol_q, tol_d;
  logic [7:0]  lim_q, lim_d;
  logic        seed_q, seed_d;

  logic [RIW-1:0] r_q, r_d, pr_q, pr_d;
  logic [CIW-1:0] c_q, c_d, pc_q, pc_d;
  logic           have_col_q, have_col_d, have_row_q, have_row_d;
  logic [7:0]     pivots_q, pivots_d;
  logic [1:0]     status_q, status_d;

  logic signed [31:0] best_q, best_d, ratio_q, ratio_d;
  logic signed [31:0] p_q, p_d, a_q, a_d, t_q, t_d, old_q, old_d, obj_q, obj_d;
  logic signed [63:0] prod_q;
  logic signed [31:0] qm_q;

  logic signed [31:0] rs_q [MAX_ROWS];
  logic signed [31:0] rs_d [MAX_ROWS];
  logic signed [31:0] costs_q [MAX_COLS];
  logic signed [31:0] costs_d [MAX_COLS];
  logic signed [31:0] rc_q [MAX_COLS];
  logic signed [31:0] rc_d [MAX_COLS];
  logic [BW-1:0]      basis_q [MAX_ROWS];
  logic [BW-1:0]      basis_d [MAX_ROWS];

  logic [DEPTH-1:0] vld_q;
  logic             rd_vld_q;

  logic               out_valid_q, out_valid_d;
  logic               kind_q, kind_d;
  logic [2:0]         brow_q, brow_d;
  logic [3:0]         bcol_q, bcol_d;
  logic signed [31:0] amount_q, amount_d;
  logic [1:0]         ostat_q, ostat_d;
  logic               last_q, last_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic               div_start, div_busy, div_done;
  logic signed [31:0] div_a, div_b, div_q;
  logic signed [31:0] mul_a, mul_b;

  logic signed [31:0] rd_val, tol_s, neg_tol, d_col, cb;
  logic [4:0]         r_eff;
  logic [5:0]         c_eff, base;
  logic [RIW-1:0]     r_last;
  logic [CIW-1:0]     c_last;
  logic [BW-1:0]      bsel;
  logic               out_free;

  sts_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_coef_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  sts_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  assign rd_val  = rd_vld_q ? $signed(ram_rdata) : '0;
  assign tol_s   = $signed({16'h0000, tol_q});
  assign neg_tol = -tol_s;
  assign d_col   = rc_q[c_q];
  assign bsel    = basis_q[r_q];
  assign cb      = ({1'b0, bsel} < (BW + 1)'(MAX_COLS)) ? costs_q[bsel[CIW-1:0]] : '0;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (rows_q == '0) begin
      r_eff = 5'd1;
    end else if ({1'b0, rows_q} > 5'(MAX_ROWS)) begin
      r_eff = 5'(MAX_ROWS);
    end else begin
      r_eff = {1'b0, rows_q};
    end
    if (cols_q < 5'd2) begin
      c_eff = 6'd2;
    end else if ({1'b0, cols_q} > 6'(MAX_COLS)) begin
      c_eff = 6'(MAX_COLS);
    end else begin
      c_eff = {1'b0, cols_q};
    end
    base   = (c_eff >= {1'b0, r_eff}) ? (c_eff - {1'b0, r_eff}) : '0;
    r_last = RIW'(r_eff - 5'd1);
    c_last = CIW'(c_eff - 6'd1);
  end

  always_comb begin
    state_d    = state_q;
    rows_d     = rows_q;
    cols_d     = cols_q;
    tol_d      = tol_q;
    lim_d      = lim_q;
    seed_d     = 1'b0;
    r_d        = r_q;
    c_d        = c_q;
    pr_d       = pr_q;
    pc_d       = pc_q;
    have_col_d = have_col_q;
    have_row_d = have_row_q;
    pivots_d   = pivots_q;
    status_d   = status_q;
    best_d     = best_q;
    ratio_d    = ratio_q;
    p_d        = p_q;
    a_d        = a_q;
    t_d        = t_q;
    old_d      = old_q;
    obj_d      = obj_q;
    rs_d       = rs_q;
    costs_d    = costs_q;
    rc_d       = rc_q;
    basis_d    = basis_q;

    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    brow_d      = brow_q;
    bcol_d      = bcol_q;
    amount_d    = amount_q;
    ostat_d     = ostat_q;
    last_d      = last_q;

    ram_we    = 1'b0;
    ram_waddr = {pr_q, c_q};
    ram_wdata = div_q;
    ram_raddr = {pr_q, c_q};
    div_start = 1'b0;
    div_a     = rs_q[r_q];
    div_b     = rd_val;
    mul_a     = rd_val;
    mul_b     = t_q;

    if (cfg_we_i) begin
      unique case (sts_pkg::cfg_e'(cfg_idx_i))
        sts_pkg::CFG_ROWS: begin
          rows_d = cfg_data_i[3:0];
          seed_d = 1'b1;
        end
        sts_pkg::CFG_COLS: begin
          cols_d = cfg_data_i[4:0];
          seed_d = 1'b1;
        end
        sts_pkg::CFG_TOL:   tol_d = cfg_data_i;
        sts_pkg::CFG_LIMIT: lim_d = cfg_data_i[7:0];
        default: ;
      endcase
    end

    if (seed_q) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        basis_d[i] = BW'(32'(base) + 32'(i));
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_pkg::req_e'(req_type_i))
            sts_pkg::REQ_LOAD_COEF: begin
              seed_d = 1'b1;
              if (32'(row_index_i) < MAX_ROWS && 32'(col_index_i) < MAX_COLS) begin
                ram_we    = 1'b1;
                ram_waddr = {RIW'(row_index_i), CIW'(col_index_i)};
                ram_wdata = value_i;
              end
            end
            sts_pkg::REQ_LOAD_RHS: begin
              seed_d = 1'b1;
              if (32'(row_index_i) < MAX_ROWS) begin
                rs_d[RIW'(row_index_i)] = value_i;
              end
            end
            sts_pkg::REQ_LOAD_COST: begin
              seed_d = 1'b1;
              if (32'(col_index_i) < MAX_COLS) begin
                costs_d[CIW'(col_index_i)] = value_i;
                rc_d[CIW'(col_index_i)]    = value_i;
              end
            end
            sts_pkg::REQ_SOLVE: begin
              c_d        = '0;
              have_col_d = 1'b0;
              pivots_d   = '0;
              state_d    = S_COL;
            end
            default: ;
          endcase
        end
      end
      S_COL: begin
        if (d_col < neg_tol && (!have_col_q || d_col < best_q)) begin
          have_col_d = 1'b1;
          best_d     = d_col;
          pc_d       = c_q;
        end
        if (c_q == c_last) begin
          state_d = S_DEC;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      S_DEC: begin
        r_d   = '0;
        obj_d = '0;
        if (!have_col_q) begin
          status_d = sts_pkg::ST_OPTIMAL;
          state_d  = S_OMUL;
        end else if (pivots_q >= lim_q) begin
          status_d = sts_pkg::ST_LIMIT;
          state_d  = S_OMUL;
        end else begin
          have_row_d = 1'b0;
          state_d    = S_RRD;
        end
      end
      S_RRD: begin
        ram_raddr = {r_q, pc_q};
        state_d   = S_RWAIT;
      end
      S_RWAIT: begin
        if (rd_val > 0) begin
          div_start = 1'b1;
          a_d       = rd_val;
          state_d   = S_RDIV;
        end else begin
          state_d = S_RNEXT;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          if (div_q > tol_s && (!have_row_q || div_q < ratio_q)) begin
            have_row_d = 1'b1;
            ratio_d    = div_q;
            pr_d       = r_q;
            p_d        = a_q;
          end
          state_d = S_RNEXT;
        end
      end
      S_RNEXT: begin
        if (r_q == r_last) begin
          if (!have_row_q) begin
            status_d = sts_pkg::ST_UNBOUNDED;
            r_d      = '0;
            obj_d    = '0;
            state_d  = S_OMUL;
          end else begin
            c_d     = '0;
            state_d = S_NRD;
          end
        end else begin
          r_d     = r_q + 1'b1;
          state_d = S_RRD;
        end
      end
      S_NRD: begin
        ram_raddr = {pr_q, c_q};
        state_d   = S_NWAIT;
      end
      S_NWAIT: begin
        div_start = 1'b1;
        div_a     = rd_val;
        div_b     = p_q;
        state_d   = S_NDIV;
      end
      S_NDIV: begin
        if (div_done) begin
          ram_we    = 1'b1;
          ram_waddr = {pr_q, c_q};
          ram_wdata = div_q;
          if (c_q == c_last) begin
            div_start = 1'b1;
            div_a     = rs_q[pr_q];
            div_b     = p_q;
            state_d   = S_NRS;
          end else begin
            c_d     = c_q + 1'b1;
            state_d = S_NRD;
          end
        end
      end
      S_NRS: begin
        if (div_done) begin
          rs_d[pr_q] = div_q;
          r_d        = '0;
          state_d    = S_EBEG;
        end
      end
      S_EBEG: begin
        if (r_q == pr_q) begin
          state_d = S_ENEXT;
        end else begin
          ram_raddr = {r_q, pc_q};
          state_d   = S_ETW;
        end
      end
      S_ETW: begin
        t_d     = rd_val;
        c_d     = '0;
        state_d = S_ERD1;
      end
      S_ERD1: begin
        ram_raddr = {pr_q, c_q};
        state_d   = S_ERD2;
      end
      S_ERD2: begin
        ram_raddr = {r_q, c_q};
        state_d   = S_EMUL;
      end
      S_EMUL: begin
        old_d   = rd_val;
        state_d = S_EWR;
      end
      S_EWR: begin
        ram_we    = 1'b1;
        ram_waddr = {r_q, c_q};
        ram_wdata = sts_pkg::q_sub(old_q, qm_q);
        if (c_q == c_last) begin
          state_d = S_ERS;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_ERD1;
        end
      end
      S_ERS: begin
        mul_a   = rs_q[pr_q];
        state_d = S_ERS2;
      end
      S_ERS2: state_d = S_ERS3;
      S_ERS3: begin
        rs_d[r_q] = sts_pkg::q_sub(rs_q[r_q], qm_q);
        state_d   = S_ENEXT;
      end
      S_ENEXT: begin
        if (r_q == r_last) begin
          t_d     = rc_q[pc_q];
          c_d     = '0;
          state_d = S_CRD;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = S_EBEG;
        end
      end
      S_CRD: begin
        ram_raddr = {pr_q, c_q};
        state_d   = S_CMUL;
      end
      S_CMUL: state_d = S_CSAT;
      S_CSAT: state_d = S_CWR;
      S_CWR: begin
        rc_d[c_q] = sts_pkg::q_sub(rc_q[c_q], qm_q);
        if (c_q == c_last) begin
          state_d = S_PIV;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_CRD;
        end
      end
      S_PIV: begin
        basis_d[pr_q] = BW'(pc_q);
        pivots_d      = pivots_q + 8'd1;
        c_d           = '0;
        have_col_d    = 1'b0;
        state_d       = S_COL;
      end
      S_OMUL: begin
        mul_a   = cb;
        mul_b   = rs_q[r_q];
        state_d = S_OSAT;
      end
      S_OSAT: state_d = S_OADD;
      S_OADD: begin
        obj_d = sts_pkg::q_add(obj_q, qm_q);
        if (r_q == r_last) begin
          state_d = S_OUT0;
        end else begin
          r_d     = r_q + 1'b1;
          state_d = S_OMUL;
        end
      end
      S_OUT0: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = sts_pkg::KIND_OBJECTIVE;
          brow_d      = '0;
          bcol_d      = '0;
          amount_d    = obj_q;
          ostat_d     = status_q;
          last_d      = 1'b0;
          r_d         = '0;
          state_d     = S_OUTR;
        end
      end
      S_OUTR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = sts_pkg::KIND_ROW;
          brow_d      = 3'(r_q);
          bcol_d      = 4'(bsel);
          amount_d    = rs_q[r_q];
          ostat_d     = status_q;
          last_d      = (r_q == r_last);
          if (r_q == r_last) begin
            state_d = S_IDLE;
          end else begin
            r_d = r_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= 4'd3;
      cols_q      <= 5'd5;
      tol_q       <= 16'd3;
      lim_q       <= 8'd64;
      seed_q      <= 1'b1;
      have_col_q  <= 1'b0;
      have_row_q  <= 1'b0;
      pivots_q    <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        rs_q[i] <= '0;
      end
      for (int i = 0; i < MAX_COLS; i++) begin
        costs_q[i] <= '0;
        rc_q[i]    <= '0;
      end
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      tol_q       <= tol_d;
      lim_q       <= lim_d;
      seed_q      <= seed_d;
      have_col_q  <= have_col_d;
      have_row_q  <= have_row_d;
      pivots_q    <= pivots_d;
      rd_vld_q    <= vld_q[ram_raddr];
      out_valid_q <= out_valid_d;
      rs_q        <= rs_d;
      costs_q     <= costs_d;
      rc_q        <= rc_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    c_q      <= c_d;
    pr_q     <= pr_d;
    pc_q     <= pc_d;
    status_q <= status_d;
    best_q   <= best_d;
    ratio_q  <= ratio_d;
    p_q      <= p_d;
    a_q      <= a_d;
    t_q      <= t_d;
    old_q    <= old_d;
    obj_q    <= obj_d;
    prod_q   <= mul_a * mul_b;
    qm_q     <= sts_pkg::q_mul_scale(prod_q);
    basis_q  <= basis_d;
    kind_q   <= kind_d;
    brow_q   <= brow_d;
    bcol_q   <= bcol_d;
    amount_q <= amount_d;
    ostat_q  <= ostat_d;
    last_q   <= last_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign basis_row_o    = brow_q;
  assign basic_column_o = bcol_q;
  assign amount_o       = amount_q;
  assign status_o       = ostat_q;
  assign last_o         = last_q;

  `STS_ASSERT_IMPL(a_div_start_idle, clk_i, rst_ni, div_start, !div_busy, "Divider started while busy.")
  `STS_ASSERT_IMPL(a_elim_not_pivot_row, clk_i, rst_ni, state_q == S_EWR, r_q != pr_q, "Elimination wrote the pivot row.")
  `STS_ASSERT_NEXT(a_last_ends_run, clk_i, rst_ni, out_valid_o && last_o && !out_stall_i, !out_valid_o, "Result followed the final item of a run.")

endmodule

// ----- design/sts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/sts_div.sv -----
// Radix-2 restoring divider for saturating Q16.16 quotients, one bit per cycle.
module sts_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] quot_o
);

  localparam int QW = 48;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [31:0]        rem_q, rem_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [31:0]        ub_q, ub_d;
  logic               neg_q, neg_d;
  logic signed [31:0] res_q, res_d;

  logic [32:0]   rem_sh;
  logic          ge;
  logic [QW-1:0] mag;
  logic [31:0]   ua;

  always_comb begin
    rem_sh = {rem_q, quo_q[QW-1]};
    ge     = rem_sh >= {1'b0, ub_q};
    mag    = {quo_q[QW-2:0], ge};
    ua     = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ub_d   = ub_q;
    neg_d  = neg_q;
    res_d  = res_q;

    if (start_i) begin
      if (divisor_i == '0) begin
        done_d = 1'b1;
        if (dividend_i > 0) begin
          res_d = sts_pkg::Q_MAX;
        end else if (dividend_i < 0) begin
          res_d = sts_pkg::Q_MIN;
        end else begin
          res_d = '0;
        end
      end else begin
        busy_d = 1'b1;
        cnt_d  = 6'(QW - 1);
        rem_d  = '0;
        quo_d  = {ua, 16'h0000};
        ub_d   = divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
        neg_d  = dividend_i[31] ^ divisor_i[31];
      end
    end else if (busy_q) begin
      rem_d = ge ? 32'(rem_sh - {1'b0, ub_q}) : rem_sh[31:0];
      quo_d = mag;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (neg_q) begin
          res_d = (mag > QW'(64'h8000_0000)) ? sts_pkg::Q_MIN : (~mag[31:0] + 32'd1);
        end else begin
          res_d = (mag > QW'(64'h7FFF_FFFF)) ? sts_pkg::Q_MAX : mag[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ub_q  <= ub_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench of the simplex tableau solver with a pivoting scoreboard.
module tb;
  import sts_pkg::*;

  typedef struct {
    kind_e             kind;
    logic [2:0]        row;
    logic [3:0]        col;
    logic signed [31:0] amount;
    status_e           status;
    logic              last;
  } solve_result_t;

  class tableau_scoreboard;
    int coef[8][16];
    int rhs[8];
    int cost[16];
    int rcost[16];
    int basis[8];
    int rows_reg, cols_reg, tol_reg, limit_reg;
    int errors;
    solve_result_t awaited[$];

    function new();
      rows_reg = 3; cols_reg = 5; tol_reg = 3; limit_reg = 64; errors = 0;
      foreach (coef[r, c]) coef[r][c] = 0;
      foreach (rhs[r]) rhs[r] = 0;
      foreach (cost[c]) begin
        cost[c] = 0; rcost[c] = 0;
      end
      reseed();
    endfunction

    function int n_rows();
      return rows_reg < 1 ? 1 : (rows_reg > 8 ? 8 : rows_reg);
    endfunction

    function int n_cols();
      return cols_reg < 2 ? 2 : (cols_reg > 16 ? 16 : cols_reg);
    endfunction

    function void reseed();
      int base;
      base = n_cols() >= n_rows() ? n_cols() - n_rows() : 0;
      for (int r = 0; r < 8; r++) basis[r] = base + r;
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function int fx_mul(int a, int b);
      return sat((longint'(a) * longint'(b)) / 65536);
    endfunction

    function int fx_div(int a, int b);
      if (b == 0) return a > 0 ? 32'sh7FFFFFFF : (a < 0 ? 32'sh80000000 : 0);
      return sat((longint'(a) * 65536) / longint'(b));
    endfunction

    function void write_reg(cfg_e idx, int data);
      case (idx)
        CFG_ROWS: begin
          rows_reg = data & 15; reseed();
        end
        CFG_COLS: begin
          cols_reg = data & 31; reseed();
        end
        CFG_TOL: tol_reg = data & 16'hFFFF;
        default: limit_reg = data & 8'hFF;
      endcase
    endfunction

    function void note_item(req_e req, int ri, int ci, int val);
      int nr, nc, pc, pr, best, best_ratio, p, t, q, pivots, obj, cb;
      bit have_col, have_row;
      status_e st;
      solve_result_t res;
      if (req != REQ_SOLVE) begin
        if (req == REQ_LOAD_COEF) coef[ri][ci] = val;
        else if (req == REQ_LOAD_RHS) rhs[ri] = val;
        else begin
          cost[ci] = val; rcost[ci] = val;
        end
        reseed();
        return;
      end
      nr = n_rows(); nc = n_cols(); pivots = 0; st = ST_OPTIMAL;
      forever begin
        have_col = 0; have_row = 0; pc = 0; pr = 0; best = 0; best_ratio = 0;
        for (int c = 0; c < nc; c++)
          if (rcost[c] < -tol_reg && (!have_col || rcost[c] < best)) begin
            have_col = 1; best = rcost[c]; pc = c;
          end
        if (!have_col) begin
          st = ST_OPTIMAL; break;
        end
        if (pivots >= limit_reg) begin
          st = ST_LIMIT; break;
        end
        for (int r = 0; r < nr; r++) begin
          if (coef[r][pc] <= 0) continue;
          q = fx_div(rhs[r], coef[r][pc]);
          if (q > tol_reg && (!have_row || q < best_ratio)) begin
            have_row = 1; best_ratio = q; pr = r;
          end
        end
        if (!have_row) begin
          st = ST_UNBOUNDED; break;
        end
        p = coef[pr][pc];
        for (int c = 0; c < nc; c++) coef[pr][c] = fx_div(coef[pr][c], p);
        rhs[pr] = fx_div(rhs[pr], p);
        for (int r = 0; r < nr; r++) begin
          if (r == pr) continue;
          t = coef[r][pc];
          for (int c = 0; c < nc; c++)
            coef[r][c] = sat(longint'(coef[r][c]) - fx_mul(coef[pr][c], t));
          rhs[r] = sat(longint'(rhs[r]) - fx_mul(rhs[pr], t));
        end
        t = rcost[pc];
        for (int c = 0; c < nc; c++)
          rcost[c] = sat(longint'(rcost[c]) - fx_mul(coef[pr][c], t));
        basis[pr] = pc;
        pivots++;
      end
      obj = 0;
      for (int r = 0; r < nr; r++) begin
        cb = basis[r] < 16 ? cost[basis[r]] : 0;
        obj = sat(longint'(obj) + fx_mul(cb, rhs[r]));
      end
      res = '{KIND_OBJECTIVE, 3'd0, 4'd0, obj, st, 1'b0};
      awaited.push_back(res);
      for (int r = 0; r < nr; r++) begin
        res = '{KIND_ROW, r[2:0], basis[r][3:0], rhs[r], st, r + 1 == nr};
        awaited.push_back(res);
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(solve_result_t got);
      solve_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected item amount=%h", got.amount));
        return;
      end
      want = awaited.pop_front();
      if (got.kind != want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
      if (got.row != want.row) report($sformatf("row %0d want %0d", got.row, want.row));
      if (got.col != want.col) report($sformatf("column %0d want %0d", got.col, want.col));
      if (got.amount != want.amount)
        report($sformatf("amount %h want %h", got.amount, want.amount));
      if (got.status != want.status)
        report($sformatf("status %0d want %0d", got.status, want.status));
      if (got.last != want.last) report($sformatf("last %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [2:0] row_index_i = '0;
  logic [3:0] col_index_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [2:0] basis_row_o;
  logic [3:0] basic_column_o;
  logic signed [31:0] amount_o;
  logic [1:0] status_o;
  logic last_o;

  simplex_tableau_solver dut (.*);

  tableau_scoreboard board = new();
  int sent = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_request = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 8000000) begin
      $display("[simplex_tableau_solver] ERROR");
      $finish;
    end
  end

  // Receiver stall: random bursts, one long hold-off on request, none at the end.
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        n = 0;
        while (n < 4000) begin
          @(posedge clk_i);
          n++;
        end
        out_stall_i <= 1'b0;
        hold_request = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    solve_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{kind_e'(kind_o), basis_row_o, basic_column_o, amount_o,
              status_e'(status_o), last_o};
      board.check_result(got);
    end
  end

  task send_item(req_e req, int ri, int ci, int val);
    bit taken;
    in_valid_i <= 1'b1;
    req_type_i <= req;
    row_index_i <= ri[2:0];
    col_index_i <= ci[3:0];
    value_i <= val;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    board.note_item(req, ri, ci, val);
    sent++;
    if (sent > 360) quiet = 1;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task drain();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task write_reg(cfg_e idx, int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task set_shape(int rows, int cols, int tol, int lim);
    drain();
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_TOL, tol);
    write_reg(CFG_LIMIT, lim);
  endtask

  function int entry_value();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 65535);
      default: return ($urandom_range(0, 8) << 16) | ($urandom_range(0, 3) << 14);
    endcase
  endfunction

  task load_problem();
    int nr, nc, base;
    nr = board.n_rows(); nc = board.n_cols();
    base = nc >= nr ? nc - nr : 0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++)
        send_item(REQ_LOAD_COEF, r, c,
                  c >= base ? ((c == base + r) ? 32'h10000 : 0) : entry_value());
      send_item(REQ_LOAD_RHS, r, 0, $urandom_range(1, 40) << 16);
    end
    for (int c = 0; c < nc; c++)
      send_item(REQ_LOAD_COST, 0, c,
                c < base ? -($urandom_range(0, 9) << 16) - $urandom_range(0, 65535) : 0);
    send_item(REQ_SOLVE, $urandom_range(0, 7), $urandom_range(0, 15), $urandom());
    if ($urandom_range(0, 3) == 0) send_item(REQ_SOLVE, 0, 0, 0);
  endtask

  task noise(int n);
    req_e req;
    repeat (n) begin
      req = req_e'($urandom_range(0, 3));
      send_item(req, $urandom_range(0, 7), $urandom_range(0, 15), $urandom());
    end
  endtask

  initial begin
    int r, c;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small textbook problem on the reset shape, then a re-solve.
    send_item(REQ_LOAD_COEF, 0, 0, 32'h10000);
    send_item(REQ_LOAD_COEF, 0, 2, 32'h10000);
    send_item(REQ_LOAD_COEF, 1, 1, 32'h20000);
    send_item(REQ_LOAD_COEF, 1, 3, 32'h10000);
    send_item(REQ_LOAD_COEF, 2, 0, 32'h30000);
    send_item(REQ_LOAD_COEF, 2, 1, 32'h20000);
    send_item(REQ_LOAD_COEF, 2, 4, 32'h10000);
    send_item(REQ_LOAD_RHS, 0, 0, 32'h40000);
    send_item(REQ_LOAD_RHS, 1, 0, 32'hC0000);
    send_item(REQ_LOAD_RHS, 2, 0, 32'h120000);
    send_item(REQ_LOAD_COST, 0, 0, -32'sh30000);
    send_item(REQ_LOAD_COST, 0, 1, -32'sh50000);
    send_item(REQ_SOLVE, 0, 0, 0);
    send_item(REQ_SOLVE, 7, 15, -1);
    // Extreme values, a column with no positive entry, and full index fields.
    send_item(REQ_LOAD_COEF, 7, 15, 32'sh7FFFFFFF);
    send_item(REQ_LOAD_RHS, 2, 0, 32'sh80000000);
    send_item(REQ_LOAD_COST, 0, 3, 32'sh80000000);
    send_item(REQ_LOAD_COEF, 0, 3, 32'sh80000000);
    send_item(REQ_LOAD_COEF, 1, 3, 0);
    send_item(REQ_LOAD_COEF, 2, 3, -32'sh10000);
    send_item(REQ_SOLVE, 0, 0, 0);
    send_item(REQ_LOAD_RHS, 7, 0, 32'sh7FFFFFFF);
    send_item(REQ_SOLVE, 0, 0, 0);

    // The sender pauses until every result is back; the receiver then holds off
    // long enough for the block to stall its input.
    drain();
    hold_request = 1;
    load_problem();
    noise(6);

    set_shape(1, 2, 0, 255);
    load_problem();
    set_shape(0, 1, 16'hFFFF, 0);
    load_problem();
    set_shape(8, 16, 3, 3);
    load_problem();
    set_shape(15, 31, 1, 1);
    send_item(REQ_SOLVE, 0, 0, 0);
    set_shape(4, 3, 3, 4);
    load_problem();
    noise(8);
    while (sent < 420) begin
      r = $urandom_range(1, 4);
      c = r + $urandom_range(1, 4);
      set_shape(r, c, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 3,
                $urandom_range(1, 12));
      load_problem();
      if ($urandom_range(0, 2) == 0) noise($urandom_range(2, 8));
    end

    drain();
    if (board.errors == 0) begin
      $display("[simplex_tableau_solver] OK");
    end else begin
      $display("[simplex_tableau_solver] ERROR");
    end
    $finish;
  end
endmodule
